// ===== design/rts_pkg.sv =====
// Shared types and codes for the recurring timer scheduler.
`default_nettype none
package rts_pkg;

  localparam int unsigned IntervalBits = 16;

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;

  localparam logic [2:0] ST_NOTHING   = 3'd0;
  localparam logic [2:0] ST_SCHEDULED = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_FIRED     = 3'd3;
  localparam logic [2:0] ST_COMPLETED = 3'd4;
  localparam logic [2:0] ST_NO_FLIGHT = 3'd5;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IntervalBits-1:0] interval_ms;
    logic                    keep_running;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  task_handle;
    logic [31:0] due_time;
    logic [4:0]  pending_count;
  } out_word_t;

endpackage
`default_nettype wire

// ===== design/rts_fire_pick.sv =====
// Running selection of the most overdue armed slot during a table scan.
`default_nettype none
module rts_fire_pick #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       valid_i,
  input  wire logic [$clog2(SLOTS)-1:0]   slot_i,
  input  wire logic                       armed_i,
  input  wire logic [TIME_BITS-1:0]       deadline_i,
  input  wire logic [TIME_BITS-1:0]       now_i,
  output logic                            found_o,
  output logic [$clog2(SLOTS)-1:0]        slot_o,
  output logic [TIME_BITS-1:0]            deadline_o
);

  localparam int unsigned SW = $clog2(SLOTS);

  logic [TIME_BITS-1:0] late;
  logic                 take;
  logic                 found_q;
  logic [SW-1:0]        slot_q;
  logic [TIME_BITS-1:0] dl_q;
  logic [TIME_BITS-1:0] late_q;

  assign late = now_i - deadline_i;
  assign take = valid_i && armed_i && !late[TIME_BITS-1] && (!found_q || (late > late_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !start_i) begin
      slot_q <= slot_i;
      dl_q   <= deadline_i;
      late_q <= late;
    end
  end

  assign found_o    = found_q;
  assign slot_o     = slot_q;
  assign deadline_o = dl_q;

endmodule
`default_nettype wire

// ===== design/recurring_timer_scheduler_top.sv =====
// Recurring timer scheduler: earliest-deadline timer queue over a slot table.
// Items are handled one at a time. A schedule word walks the slot table for
// the lowest free slot, one slot per cycle. A tick word scans every slot
// through the single read port of the entry RAM and one shared late-time
// comparator, unless a task is in flight; then it goes straight to the
// finish step. A completion word with a task in flight first does a
// read-modify-write of the slot entry before the same scan. An unknown
// command goes straight to the finish step. One result word is produced per
// input word and waits in an output register; the next input word is taken
// meanwhile, and the finish step holds while an earlier result is unread.
`default_nettype none
module recurring_timer_scheduler_top #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rts_pkg::in_word_t   in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rts_pkg::out_word_t       out_word_o
);

  import rts_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned EW = TIME_BITS + IntervalBits;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FREE   = 3'd1;
  localparam logic [2:0] S_CMP_RD = 3'd2;
  localparam logic [2:0] S_CMP_WR = 3'd3;
  localparam logic [2:0] S_FIRE   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_PICK   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [TB-1:0]           now_q, now_d;
  logic [SLOTS-1:0]        armed_q, armed_d;
  logic                    in_flight_q, in_flight_d;
  logic [SW-1:0]           ifs_q, ifs_d;
  logic [CW-1:0]           pending_q, pending_d;
  logic [SW-1:0]           idx_q, idx_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_q, out_d;
  logic [IntervalBits-1:0] ivl_q, ivl_d;
  logic                    keep_q, keep_d;
  logic [2:0]              st_q, st_d;
  logic [SW-1:0]           hdl_q, hdl_d;
  logic [TB-1:0]           due_q, due_d;
  logic                    rv_q;
  logic [SW-1:0]           ridx_q;

  logic [EW-1:0]           mem_q [SLOTS];
  logic [EW-1:0]           rd_q;
  logic                    we;
  logic [SW-1:0]           wa;
  logic [EW-1:0]           wd;
  logic [SW-1:0]           ra;

  logic                    last;
  logic                    slot_free;
  logic [TB-1:0]           rearm_dl;
  logic                    pick_found;
  logic [SW-1:0]           pick_slot;
  logic [TB-1:0]           pick_dl;

  assign last      = (idx_q == SW'(SLOTS - 1));
  assign slot_free = !armed_q[idx_q] && !(in_flight_q && (ifs_q == idx_q));
  assign rearm_dl  = rd_q[TB-1:0] + TB'(rd_q[EW-1:TB]);
  assign ra        = (state_q == S_CMP_RD) ? ifs_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  rts_fire_pick #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_IDLE),
    .valid_i    (rv_q),
    .slot_i     (ridx_q),
    .armed_i    (armed_q[ridx_q]),
    .deadline_i (rd_q[TB-1:0]),
    .now_i      (now_q),
    .found_o    (pick_found),
    .slot_o     (pick_slot),
    .deadline_o (pick_dl)
  );

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    armed_d     = armed_q;
    in_flight_d = in_flight_q;
    ifs_d       = ifs_q;
    pending_d   = pending_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ivl_d       = ivl_q;
    keep_d      = keep_q;
    st_d        = st_q;
    hdl_d       = hdl_q;
    due_d       = due_q;
    we          = 1'b0;
    wa          = idx_q;
    wd          = {ivl_q, now_q + TB'(ivl_q)};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ivl_d  = in_word_i.interval_ms;
          keep_d = in_word_i.keep_running;
          st_d   = ST_NOTHING;
          hdl_d  = '0;
          due_d  = '0;
          idx_d  = '0;
          unique case (in_word_i.cmd)
            CMD_SCHEDULE: state_d = S_FREE;
            CMD_TICK: begin
              now_d   = now_q + TB'(1);
              state_d = in_flight_q ? S_FINISH : S_FIRE;
            end
            CMD_COMPLETE: begin
              if (in_flight_q) begin
                state_d = S_CMP_RD;
              end else begin
                st_d    = ST_NO_FLIGHT;
                state_d = S_FIRE;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_FREE: begin
        if (slot_free) begin
          we             = 1'b1;
          armed_d[idx_q] = 1'b1;
          pending_d      = pending_q + CW'(1);
          st_d           = ST_SCHEDULED;
          hdl_d          = idx_q;
          due_d          = now_q + TB'(ivl_q);
          state_d        = S_FINISH;
        end else if (last) begin
          st_d    = ST_REJECTED;
          state_d = S_FINISH;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      S_CMP_RD: state_d = S_CMP_WR;
      S_CMP_WR: begin
        in_flight_d = 1'b0;
        st_d        = ST_COMPLETED;
        hdl_d       = ifs_q;
        if (keep_q) begin
          we             = 1'b1;
          wa             = ifs_q;
          wd             = {rd_q[EW-1:TB], rearm_dl};
          armed_d[ifs_q] = 1'b1;
          pending_d      = pending_q + CW'(1);
          due_d          = rearm_dl;
        end
        state_d = S_FIRE;
      end
      S_FIRE: begin
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      S_DRAIN: state_d = S_PICK;
      S_PICK: begin
        if (pick_found) begin
          armed_d[pick_slot] = 1'b0;
          pending_d          = pending_q - CW'(1);
          in_flight_d        = 1'b1;
          ifs_d              = pick_slot;
          st_d               = ST_FIRED;
          hdl_d              = pick_slot;
          due_d              = pick_dl;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.status            = st_q;
          out_d.task_handle       = 4'(hdl_q);
          out_d.due_time          = 32'(due_q);
          out_d.pending_count     = 5'(pending_q);
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      armed_q     <= '0;
      in_flight_q <= 1'b0;
      ifs_q       <= '0;
      pending_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      armed_q     <= armed_d;
      in_flight_q <= in_flight_d;
      ifs_q       <= ifs_d;
      pending_q   <= pending_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      rv_q        <= (state_q == S_FIRE);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    ivl_q  <= ivl_d;
    keep_q <= keep_d;
    st_q   <= st_d;
    hdl_q  <= hdl_d;
    due_q  <= due_d;
    ridx_q <= idx_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_flight_not_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q |-> !armed_q[ifs_q])
    else $error("in-flight slot is still armed");

  a_pending_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == CW'($countones(armed_q)))
    else $error("pending count out of step with armed slots");

  a_fired_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && st_q == ST_FIRED) |-> in_flight_q)
    else $error("fired word without a task in flight");

  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP_WR) |=> !in_flight_q || (state_q == S_FINISH))
    else $error("completion left a task in flight");

endmodule
`default_nettype wire

// ===== bench/rts_checker.sv =====
// Checker that predicts every result word of the timer scheduler and scores it.
`timescale 1ns / 1ps
module rts_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire rts_pkg::in_word_t  in_word_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire rts_pkg::out_word_t out_word_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             words_owed_o
);

  import rts_pkg::*;

  localparam int unsigned SLOTS = 16;

  logic [31:0]      now_ms;
  logic [31:0]      slot_due [SLOTS];
  logic [15:0]      slot_period [SLOTS];
  logic [SLOTS-1:0] slot_armed;
  logic             running;
  logic [3:0]       running_slot;
  out_word_t        scheduler_answers [$];
  out_word_t        want;

  function automatic int fire_earliest();
    int          best;
    int          i;
    logic [31:0] best_late;
    logic [31:0] late;
    best = -1;
    best_late = '0;
    if (running) begin
      return -1;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (slot_armed[i]) begin
        late = now_ms - slot_due[i];
        if (!late[31] && (best < 0 || late > best_late)) begin
          best = i;
          best_late = late;
        end
      end
    end
    if (best >= 0) begin
      slot_armed[best] = 1'b0;
      running = 1'b1;
      running_slot = 4'(best);
    end
    return best;
  endfunction

  function automatic out_word_t step_table(in_word_t w);
    out_word_t r;
    int        f;
    int        i;
    r = '0;
    unique case (w.cmd)
      CMD_SCHEDULE: begin
        r.status = ST_REJECTED;
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_armed[i] && !(running && running_slot == 4'(i))) begin
            slot_due[i] = now_ms + 32'(w.interval_ms);
            slot_period[i] = w.interval_ms;
            slot_armed[i] = 1'b1;
            r.status = ST_SCHEDULED;
            r.task_handle = 4'(i);
            r.due_time = slot_due[i];
            break;
          end
        end
      end
      CMD_TICK, CMD_COMPLETE: begin
        if (w.cmd == CMD_TICK) begin
          now_ms = now_ms + 32'd1;
        end else if (running) begin
          running = 1'b0;
          r.status = ST_COMPLETED;
          r.task_handle = running_slot;
          if (w.keep_running) begin
            slot_due[running_slot] = slot_due[running_slot] + 32'(slot_period[running_slot]);
            slot_armed[running_slot] = 1'b1;
            r.due_time = slot_due[running_slot];
          end
        end else begin
          r.status = ST_NO_FLIGHT;
        end
        f = fire_earliest();
        if (f >= 0) begin
          r.status = ST_FIRED;
          r.task_handle = 4'(f);
          r.due_time = slot_due[f];
        end
      end
      default: begin
      end
    endcase
    r.pending_count = 5'($countones(slot_armed));
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_ms = '0;
      slot_armed = '0;
      running = 1'b0;
      running_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_due[i] = '0;
        slot_period[i] = '0;
      end
      scheduler_answers.delete();
      mismatch_count_o = 0;
      words_owed_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        scheduler_answers.push_back(step_table(in_word_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (scheduler_answers.size() == 0) begin
          $display("%0t: word expected none actual %0h", $time, out_word_i);
          mismatch_count_o++;
        end else begin
          want = scheduler_answers.pop_front();
          check_field("status", 32'(want.status), 32'(out_word_i.status));
          check_field("task_handle", 32'(want.task_handle), 32'(out_word_i.task_handle));
          check_field("due_time", want.due_time, out_word_i.due_time);
          check_field("pending_count", 32'(want.pending_count), 32'(out_word_i.pending_count));
        end
      end
      words_owed_o = scheduler_answers.size();
    end
  end

endmodule

// ===== bench/recurring_timer_scheduler_top_tb.sv =====
// Testbench top: drives schedule, tick, completion and unknown-command words into the scheduler.
`timescale 1ns / 1ps
module recurring_timer_scheduler_top_tb;
  import rts_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PER_PHASE = 208;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned mismatch_count;
  int unsigned words_owed;

  recurring_timer_scheduler_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  rts_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_word_i       (out_word),
    .mismatch_count_o (mismatch_count),
    .words_owed_o     (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  task automatic push_word(input logic [1:0] cmd, input logic [15:0] interval,
                           input logic keep);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word.cmd <= cmd;
    in_word.interval_ms <= interval;
    in_word.keep_running <= keep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic push_random();
    int unsigned pick;
    logic [1:0]  cmd;
    logic [15:0] interval;
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      cmd = CMD_SCHEDULE;
    end else if (pick < 64) begin
      cmd = CMD_TICK;
    end else if (pick < 95) begin
      cmd = CMD_COMPLETE;
    end else begin
      cmd = CMD_UNUSED;
    end
    if ($urandom_range(0, 3) == 0) begin
      interval = 16'($urandom);
    end else begin
      interval = 16'($urandom_range(0, 12));
    end
    push_word(cmd, interval, 1'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    sender_idle_pct = 22;
    receiver_idle_pct = 60;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_word(CMD_COMPLETE, 16'h0000, 1'b0);
    push_word(CMD_TICK, 16'h0000, 1'b0);
    push_word(CMD_UNUSED, 16'hffff, 1'b1);
    push_word(CMD_SCHEDULE, 16'h0000, 1'b0);
    push_word(CMD_SCHEDULE, 16'hffff, 1'b1);
    push_word(CMD_TICK, 16'h0000, 1'b0);
    push_word(CMD_COMPLETE, 16'h0000, 1'b1);
    push_word(CMD_SCHEDULE, 16'h0001, 1'b0);
    push_word(CMD_COMPLETE, 16'h0000, 1'b0);
    push_word(CMD_SCHEDULE, 16'h0001, 1'b0);
    push_word(CMD_TICK, 16'h0000, 1'b0);
    push_word(CMD_COMPLETE, 16'h0000, 1'b0);
    push_word(CMD_COMPLETE, 16'h0000, 1'b1);
    for (int k = 0; k < 15; k++) begin
      push_word(CMD_SCHEDULE, 16'(k + 2), 1'(k));
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 60;
        receiver_idle_pct = 22;
      end else if (phase == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      repeat (RANDOM_PER_PHASE) push_random();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
